>>> rtl/quadratic_root_solver_macros.svh
// Assertion shorthands used by the solver's queue.
// Each expects signals named clk and rst_n in the module that uses it.
`ifndef QUADRATIC_ROOT_SOLVER_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define QRS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qrs assertion failed");

// Consequent must hold in the cycle after the antecedent
`define QRS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qrs assertion failed");

`endif

>>> rtl/qrs_pkg.sv
`default_nettype none

package qrs_pkg;

    // Q16.16 words
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    // Discriminant magnitude: b^2 + 4|a||c| needs two words plus one bit
    localparam int DISC_BITS = 2 * WORD_BITS + 1;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    typedef enum logic [2:0] {
        KIND_INFINITE = 3'd0,
        KIND_NONE     = 3'd1,
        KIND_LINEAR   = 3'd2,
        KIND_TWO_REAL = 3'd3,
        KIND_DOUBLE   = 3'd4,
        KIND_COMPLEX  = 3'd5
    } case_kind_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] coef_a;
        logic signed [WORD_BITS-1:0] coef_b;
        logic signed [WORD_BITS-1:0] coef_c;
    } coef_t;

    typedef struct packed {
        case_kind_t                  case_kind;
        logic signed [WORD_BITS-1:0] root_first;
        logic signed [WORD_BITS-1:0] root_second;
        logic                        saturated;
    } roots_t;

    // Classified item handed from the front to the back
    typedef struct packed {
        case_kind_t                  kind;
        logic signed [WORD_BITS-1:0] coef_a;
        logic signed [WORD_BITS-1:0] coef_b;
        logic signed [WORD_BITS-1:0] coef_c;
        logic [DISC_BITS-1:0]        disc;
    } qrs_item_t;

    // Magnitude of a signed word; the most negative value maps to 2^(W-1)
    function automatic logic [WORD_BITS-1:0] mag_of(input logic signed [WORD_BITS-1:0] v);
        return v[WORD_BITS-1] ? -v : v;
    endfunction

endpackage

`default_nettype wire

>>> rtl/qrs_front.sv
`default_nettype none

module qrs_front (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 coef_valid,
    output logic                coef_ready,
    input  qrs_pkg::coef_t      coef,
    output logic                item_valid,
    input  wire                 item_ready,
    output qrs_pkg::qrs_item_t  item
);
    import qrs_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int PW = 2 * W;
    localparam int DW = DISC_BITS;

    logic           f1_valid_reg;
    coef_t          f1_coef_reg;
    logic [PW-1:0]  f1_bb_reg;
    logic [PW-1:0]  f1_ac_reg;
    logic           f2_valid_reg;
    qrs_item_t      f2_item_reg;
    qrs_item_t      f2_item_next;

    logic           adv;
    logic [W-1:0]   mb;
    logic [W-1:0]   ma;
    logic [W-1:0]   mc;
    logic [DW-1:0]  bbx;
    logic [DW-1:0]  ac4;
    logic [DW-1:0]  d_sum;
    logic [DW-1:0]  d_fwd;
    logic [DW-1:0]  d_rev;
    logic           ac_pos;

    // Advance the two front stages together unless the last one is blocked
    assign adv        = !f2_valid_reg || item_ready;
    assign coef_ready = adv;

    assign mb = mag_of(coef.coef_b);
    assign ma = mag_of(coef.coef_a);
    assign mc = mag_of(coef.coef_c);

    // Stage one: the two products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f1_valid_reg <= coef_valid;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_coef_reg <= coef;
            f1_bb_reg   <= PW'(mb) * PW'(mb);
            f1_ac_reg   <= PW'(ma) * PW'(mc);
            f2_item_reg <= f2_item_next;
        end
    end

    // Stage two: discriminant and case class
    // |a||c| never exceeds 2^62, so its top bit is always clear
    assign bbx    = DW'(f1_bb_reg);
    assign ac4    = {f1_ac_reg[PW-2:0], 2'b00};
    assign d_sum  = bbx + ac4;
    assign d_fwd  = bbx - ac4;
    assign d_rev  = ac4 - bbx;
    assign ac_pos = (f1_coef_reg.coef_a[W-1] == f1_coef_reg.coef_c[W-1])
                    && (f1_coef_reg.coef_c != '0);

    always_comb
    begin
        f2_item_next.coef_a = f1_coef_reg.coef_a;
        f2_item_next.coef_b = f1_coef_reg.coef_b;
        f2_item_next.coef_c = f1_coef_reg.coef_c;
        f2_item_next.disc   = d_sum;
        f2_item_next.kind   = KIND_TWO_REAL;
        priority if (f1_coef_reg.coef_a == '0)
        begin
            if (f1_coef_reg.coef_b != '0)
                f2_item_next.kind = KIND_LINEAR;
            else if (f1_coef_reg.coef_c == '0)
                f2_item_next.kind = KIND_INFINITE;
            else
                f2_item_next.kind = KIND_NONE;
        end
        else if (!ac_pos)
        begin
            f2_item_next.kind = (d_sum != '0) ? KIND_TWO_REAL : KIND_DOUBLE;
        end
        else if (bbx >= ac4)
        begin
            f2_item_next.disc = d_fwd;
            f2_item_next.kind = (d_fwd != '0) ? KIND_TWO_REAL : KIND_DOUBLE;
        end
        else
        begin
            f2_item_next.disc = d_rev;
            f2_item_next.kind = KIND_COMPLEX;
        end
    end

    assign item_valid = f2_valid_reg;
    assign item       = f2_item_reg;

endmodule

`default_nettype wire

>>> rtl/qrs_queue.sv
`default_nettype none
`include "quadratic_root_solver_macros.svh"

module qrs_queue #(
    parameter int DEPTH = qrs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push_valid,
    output logic                push_ready,
    input  qrs_pkg::qrs_item_t  push_item,
    output logic                pop_valid,
    input  wire                 pop_ready,
    output qrs_pkg::qrs_item_t  pop_item
);
    import qrs_pkg::*;

    localparam int PTW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW  = $clog2(DEPTH + 1);

    qrs_item_t       mem_reg [DEPTH];
    logic [PTW-1:0]  wr_ptr_reg;
    logic [PTW-1:0]  rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            push_fire;
    logic            pop_fire;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;
    assign pop_item   = mem_reg[rd_ptr_reg];

    // Write the incoming item at the tail
    always_ff @(posedge clk)
    begin
        if (push_fire)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    // Advance pointers and track the fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_fire)
                wr_ptr_reg <= (wr_ptr_reg == PTW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop_fire)
                rd_ptr_reg <= (rd_ptr_reg == PTW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push_fire && !pop_fire)
                count_reg <= count_reg + 1'b1;
            else if (pop_fire && !push_fire)
                count_reg <= count_reg - 1'b1;
        end
    end

    `QRS_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CW'(DEPTH))
    `QRS_ASSERT_NEXT(a_push_grows, push_fire && !pop_fire, count_reg == $past(count_reg) + 1'b1)
    `QRS_ASSERT_NEXT(a_pop_shrinks, pop_fire && !push_fire, count_reg == $past(count_reg) - 1'b1)

endmodule

`default_nettype wire

>>> rtl/qrs_back.sv
`default_nettype none

module qrs_back (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 item_valid,
    output logic                item_ready,
    input  qrs_pkg::qrs_item_t  item,
    output logic                roots_valid,
    input  wire                 roots_ready,
    output qrs_pkg::roots_t     roots
);
    import qrs_pkg::*;

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int SQ  = W + 1;          // square root steps, one result bit each
    localparam int RW  = W + 1;          // root width
    localparam int SRW = RW + 2;         // partial remainder width
    localparam int DSW = 2 * SQ;         // discriminant padded to whole digit pairs
    localparam int NMW = W + 2;          // numerator magnitude width
    localparam int NV  = NMW + 1;        // signed numerator width
    localparam int DNW = W + 1;          // denominator magnitude width
    localparam int DV  = DNW + 1;        // signed denominator width
    localparam int QW  = NMW + F;        // dividend and quotient width

    typedef struct packed {
        logic           use_lane;
        logic           neg;
        logic [DNW-1:0] den;
        logic [DNW-1:0] rem;
        logic [QW-1:0]  quo;
        logic [QW-1:0]  dvd;
    } lane_t;

    // Set up one signed division (num << F) / den
    function automatic lane_t make_lane(input logic signed [NV-1:0] num,
                                        input logic signed [DV-1:0] den);
        lane_t          l;
        logic [NV-1:0]  nm;
        logic [DV-1:0]  dm;
        nm         = num[NV-1] ? -num : num;
        dm         = den[DV-1] ? -den : den;
        l.use_lane = 1'b1;
        l.neg      = num[NV-1] ^ den[DV-1];
        l.den      = dm[DNW-1:0];
        l.rem      = '0;
        l.quo      = '0;
        l.dvd      = {nm[NMW-1:0], {F{1'b0}}};
        return l;
    endfunction

    // One quotient bit of restoring division
    function automatic lane_t div_step(input lane_t l);
        lane_t          r;
        logic [DNW:0]   rem_sh;
        logic [DNW:0]   diff;
        logic           ge;
        rem_sh = {l.rem, l.dvd[QW-1]};
        diff   = rem_sh - {1'b0, l.den};
        ge     = rem_sh >= {1'b0, l.den};
        r      = l;
        r.rem  = ge ? diff[DNW-1:0] : rem_sh[DNW-1:0];
        r.quo  = {l.quo[QW-2:0], ge};
        r.dvd  = {l.dvd[QW-2:0], 1'b0};
        return r;
    endfunction

    // Clip to the word range and apply the sign: {saturated, value}
    function automatic logic [W:0] finish(input lane_t l);
        logic [QW-1:0]  lim;
        logic [QW-1:0]  qs;
        logic [QW-1:0]  qn;
        logic           sat;
        lim = (QW'(1) << (W - 1)) - QW'(!l.neg);
        sat = l.quo > lim;
        qs  = sat ? lim : l.quo;
        qn  = -qs;
        return {sat, l.neg ? qn[W-1:0] : qs[W-1:0]};
    endfunction

    logic en;

    logic             sq_valid_reg [SQ];
    qrs_item_t        sq_item_reg  [SQ];
    logic [SRW-1:0]   sq_rem_reg   [SQ];
    logic [RW-1:0]    sq_root_reg  [SQ];
    logic [DSW-1:0]   sq_bits_reg  [SQ];

    logic             pr_valid_reg;
    case_kind_t       pr_kind_reg;
    lane_t            pr_a_reg;
    lane_t            pr_b_reg;
    lane_t            pr_a_next;
    lane_t            pr_b_next;

    logic             dv_valid_reg [QW];
    case_kind_t       dv_kind_reg  [QW];
    lane_t            dv_a_reg     [QW];
    lane_t            dv_b_reg     [QW];

    logic             out_valid_reg;
    roots_t           out_roots_reg;
    roots_t           out_roots_next;

    // The whole back moves as one; it stops only when a result waits
    assign en          = !out_valid_reg || roots_ready;
    assign item_ready  = en;
    assign roots_valid = out_valid_reg;
    assign roots       = out_roots_reg;

    // Square root of the discriminant, two radicand bits a stage
    for (genvar i = 0; i < SQ; i++)
    begin : g_sq
        logic             v_in;
        qrs_item_t        it_in;
        logic [SRW-1:0]   rem_in;
        logic [RW-1:0]    root_in;
        logic [DSW-1:0]   bits_in;
        logic [SRW-1:0]   rem_sh;
        logic [SRW-1:0]   trial;
        logic             ge;

        if (i == 0)
        begin : g_first
            assign v_in    = item_valid;
            assign it_in   = item;
            assign rem_in  = '0;
            assign root_in = '0;
            assign bits_in = DSW'(item.disc);
        end
        else
        begin : g_rest
            assign v_in    = sq_valid_reg[i-1];
            assign it_in   = sq_item_reg[i-1];
            assign rem_in  = sq_rem_reg[i-1];
            assign root_in = sq_root_reg[i-1];
            assign bits_in = sq_bits_reg[i-1];
        end

        assign rem_sh = {rem_in[SRW-3:0], bits_in[DSW-1 -: 2]};
        assign trial  = {root_in, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_valid_reg[i] <= 1'b0;
            else if (en)
                sq_valid_reg[i] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_item_reg[i] <= it_in;
                sq_rem_reg[i]  <= ge ? rem_sh - trial : rem_sh;
                sq_root_reg[i] <= {root_in[RW-2:0], ge};
                sq_bits_reg[i] <= {bits_in[DSW-3:0], 2'b00};
            end
        end
    end

    // Pick numerators and denominators for the two dividers
    always_comb
    begin
        logic signed [NV-1:0]  bx;
        logic signed [NV-1:0]  cx;
        logic signed [NV-1:0]  sx;
        logic signed [NV-1:0]  nb;
        logic signed [DV-1:0]  ax;
        logic signed [DV-1:0]  bd;
        logic signed [DV-1:0]  two_a;
        logic signed [DV-1:0]  two_a_abs;
        qrs_item_t             it;
        it        = sq_item_reg[SQ-1];
        bx        = NV'(it.coef_b);
        cx        = NV'(it.coef_c);
        sx        = $signed({2'b00, sq_root_reg[SQ-1]});
        nb        = -bx;
        ax        = DV'(it.coef_a);
        bd        = DV'(it.coef_b);
        two_a     = ax + ax;
        two_a_abs = two_a[DV-1] ? -two_a : two_a;
        pr_a_next = '0;
        pr_b_next = '0;
        unique case (it.kind)
            KIND_LINEAR:
            begin
                pr_a_next = make_lane(-cx, bd);
            end
            KIND_TWO_REAL:
            begin
                pr_a_next = make_lane(nb + sx, two_a);
                pr_b_next = make_lane(nb - sx, two_a);
            end
            KIND_DOUBLE:
            begin
                pr_a_next = make_lane(nb, two_a);
            end
            KIND_COMPLEX:
            begin
                pr_a_next = make_lane(nb, two_a);
                pr_b_next = make_lane(sx, two_a_abs);
            end
            KIND_INFINITE, KIND_NONE:
            begin
                pr_a_next = '0;
                pr_b_next = '0;
            end
            default:
            begin
                pr_a_next = '0;
                pr_b_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pr_valid_reg <= 1'b0;
        else if (en)
            pr_valid_reg <= sq_valid_reg[SQ-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr_kind_reg <= sq_item_reg[SQ-1].kind;
            pr_a_reg    <= pr_a_next;
            pr_b_reg    <= pr_b_next;
        end
    end

    // Two dividers side by side, one quotient bit a stage
    for (genvar j = 0; j < QW; j++)
    begin : g_dv
        logic        v_in;
        case_kind_t  k_in;
        lane_t       a_in;
        lane_t       b_in;

        if (j == 0)
        begin : g_first
            assign v_in = pr_valid_reg;
            assign k_in = pr_kind_reg;
            assign a_in = pr_a_reg;
            assign b_in = pr_b_reg;
        end
        else
        begin : g_rest
            assign v_in = dv_valid_reg[j-1];
            assign k_in = dv_kind_reg[j-1];
            assign a_in = dv_a_reg[j-1];
            assign b_in = dv_b_reg[j-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[j] <= 1'b0;
            else if (en)
                dv_valid_reg[j] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_kind_reg[j] <= k_in;
                dv_a_reg[j]    <= div_step(a_in);
                dv_b_reg[j]    <= div_step(b_in);
            end
        end
    end

    // Saturate, sign and gather the result
    always_comb
    begin
        logic [W:0]  fa;
        logic [W:0]  fb;
        lane_t       la;
        lane_t       lb;
        la = dv_a_reg[QW-1];
        lb = dv_b_reg[QW-1];
        fa = finish(la);
        fb = finish(lb);
        out_roots_next.case_kind   = dv_kind_reg[QW-1];
        out_roots_next.root_first  = la.use_lane ? fa[W-1:0] : '0;
        out_roots_next.root_second = lb.use_lane ? fb[W-1:0] : '0;
        out_roots_next.saturated   = (la.use_lane && fa[W]) || (lb.use_lane && fb[W]);
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_valid_reg[QW-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_roots_reg <= out_roots_next;
    end

endmodule

`default_nettype wire

>>> rtl/quadratic_root_solver.sv
// Channel   Direction  Payload           Handshake
// coef      in         qrs_pkg::coef_t   coef_valid / coef_ready
// roots     out        qrs_pkg::roots_t  root_valid / root_ready
//
// One item enters per cycle and one result leaves per cycle when root_ready stays high.
// The path runs through two front stages (products, then discriminant), the queue,
// 33 square root stages, a setup stage, 50 quotient-bit stages of the two dividers and
// the output register for Q16.16; the digit-serial root and divide pipelines make up
// most of that path.
// Reset clears only valid bits, pointers and counts; no clearing pass.
// A stalled output freezes the back; the queue lets the front keep taking items until it fills.
`default_nettype none

module quadratic_root_solver #(
    parameter int QUEUE_DEPTH = qrs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              coef_valid,
    output logic             coef_ready,
    input  qrs_pkg::coef_t   coef,
    output logic             root_valid,
    input  wire              root_ready,
    output qrs_pkg::roots_t  roots
);
    import qrs_pkg::*;

    logic       fr_valid;
    logic       fr_ready;
    qrs_item_t  fr_item;
    logic       bk_valid;
    logic       bk_ready;
    qrs_item_t  bk_item;

    // Classify and form the discriminant
    qrs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .coef_valid (coef_valid),
        .coef_ready (coef_ready),
        .coef       (coef),
        .item_valid (fr_valid),
        .item_ready (fr_ready),
        .item       (fr_item)
    );

    // Decouple front and back
    qrs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_item  (fr_item),
        .pop_valid  (bk_valid),
        .pop_ready  (bk_ready),
        .pop_item   (bk_item)
    );

    // Square root, divisions and saturation
    qrs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (bk_valid),
        .item_ready  (bk_ready),
        .item        (bk_item),
        .roots_valid (root_valid),
        .roots_ready (root_ready),
        .roots       (roots)
    );

endmodule

`default_nettype wire
